/* rtl/tpp_pkg.sv */
// Package: constants, types and digit helpers of the touch packet parser.
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

    localparam int PACKET_BYTES = 10;
    localparam int COUNT_W      = 4;
    localparam int ACC_W        = 14;   // four decimal digits, up to 9999
    localparam int POS_W        = 16;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_TOUCH   = 8'd84;
    localparam logic [7:0] CH_RELEASE = 8'd82;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;

    localparam logic [COUNT_W-1:0] POS_TYPE    = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_X_FIRST = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_X_LAST  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_COMMA   = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_Y_FIRST = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_Y_LAST  = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(PACKET_BYTES);

    localparam logic [POS_W-1:0] Y_ORIGIN = POS_W'(3072);

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } tpp_hold_t;

    // Payload of one result item
    typedef struct packed {
        logic                    packet_ok;
        logic [POS_W-1:0]        x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic                    touched;
    } tpp_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc * 10 + digit value, by shifts
    function automatic logic [ACC_W-1:0] digit_step(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [ACC_W+3:0] sum;
        logic [7:0]       d;
        d   = c - CH_ZERO;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(ACC_W-4){1'b0}}, d};
        return sum[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/tpp_in_if.sv */
// Interface: byte channel into the parser.
`timescale 1ns / 1ps
`default_nettype none

interface tpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/tpp_out_if.sv */
// Interface: result channel out of the parser.
`timescale 1ns / 1ps
`default_nettype none

interface tpp_out_if;
    logic               valid;
    logic               ready;
    logic               packet_ok;
    logic [15:0]        x_pos;
    logic signed [15:0] y_pos;
    logic               touched;

    modport source (output valid, output packet_ok, output x_pos, output y_pos,
                    output touched, input ready);
    modport sink   (input valid, input packet_ok, input x_pos, input y_pos,
                    input touched, output ready);
endinterface

`default_nettype wire

/* rtl/tpp_in_stage.sv */
// Input register: holds one received byte until the accumulator takes it.
`timescale 1ns / 1ps
`default_nettype none

module tpp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    tpp_in_if.sink            bytes,
    input  logic              advance,
    output tpp_pkg::tpp_hold_t hold
);
    import tpp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       take;

    assign bytes.ready = !valid_reg || advance;
    assign take        = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= bytes.rx_byte;
        end
    end

    assign hold.valid = valid_reg;
    assign hold.data  = data_reg;

endmodule

`default_nettype wire

/* rtl/tpp_accum.sv */
// Field accumulator: counts bytes, parses digits on arrival, builds the result.
`timescale 1ns / 1ps
`default_nettype none

module tpp_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpp_pkg::tpp_hold_t   hold,
    input  logic                 can_load,
    output logic                 advance,
    output logic                 load,
    output tpp_pkg::tpp_result_t result
);
    import tpp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         type_reg;
    logic [7:0]         type_next;
    logic               comma_reg;
    logic               comma_next;
    logic [ACC_W-1:0]   x_acc_reg;
    logic [ACC_W-1:0]   x_acc_next;
    logic               x_run_reg;
    logic               x_run_next;
    logic [ACC_W-1:0]   y_acc_reg;
    logic [ACC_W-1:0]   y_acc_next;
    logic               y_run_reg;
    logic               y_run_next;

    logic               is_cr;
    logic               store;
    logic               ok;
    logic [POS_W-1:0]   y_times3;

    assign is_cr   = (hold.data == CH_CR);
    assign advance = hold.valid && (!is_cr || can_load);
    assign load    = advance && is_cr;
    assign store   = advance && !is_cr && (count_reg < COUNT_FULL);

    always_comb
    begin
        count_next = count_reg;
        type_next  = type_reg;
        comma_next = comma_reg;
        x_acc_next = x_acc_reg;
        x_run_next = x_run_reg;
        y_acc_next = y_acc_reg;
        y_run_next = y_run_reg;
        if (load)
        begin
            count_next = '0;
        end
        else if (store)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (count_reg == POS_TYPE)
            begin
                // first byte of a packet: restart both digit fields
                type_next  = hold.data;
                x_acc_next = '0;
                x_run_next = 1'b1;
                y_acc_next = '0;
                y_run_next = 1'b1;
            end
            else if (count_reg == POS_COMMA)
            begin
                comma_next = (hold.data == CH_COMMA);
            end
            else if (count_reg >= POS_X_FIRST && count_reg <= POS_X_LAST)
            begin
                if (x_run_reg && is_digit(hold.data))
                begin
                    x_acc_next = digit_step(x_acc_reg, hold.data);
                end
                else
                begin
                    x_run_next = 1'b0;
                end
            end
            else if (count_reg >= POS_Y_FIRST && count_reg <= POS_Y_LAST)
            begin
                if (y_run_reg && is_digit(hold.data))
                begin
                    y_acc_next = digit_step(y_acc_reg, hold.data);
                end
                else
                begin
                    y_run_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        comma_reg <= comma_next;
        x_acc_reg <= x_acc_next;
        x_run_reg <= x_run_next;
        y_acc_reg <= y_acc_next;
        y_run_reg <= y_run_next;
    end

    assign ok = (count_reg == COUNT_FULL) && comma_reg
             && ((type_reg == CH_TOUCH) || (type_reg == CH_RELEASE));

    assign y_times3 = {1'b0, y_acc_reg, 1'b0} + {2'b00, y_acc_reg};

    always_comb
    begin
        result.packet_ok = ok;
        result.x_pos     = '0;
        result.y_pos     = '0;
        result.touched   = 1'b0;
        if (ok)
        begin
            result.x_pos   = {x_acc_reg, 2'b00};
            result.y_pos   = Y_ORIGIN - y_times3;
            result.touched = (type_reg == CH_TOUCH);
        end
    end

endmodule

`default_nettype wire

/* rtl/tpp_result_reg.sv */
// Result register: holds one result item until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module tpp_result_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tpp_pkg::tpp_result_t result,
    output logic                 can_load,
    tpp_out_if.source            results
);
    import tpp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tpp_result_t data_reg;

    assign can_load = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign results.valid     = valid_reg;
    assign results.packet_ok = data_reg.packet_ok;
    assign results.x_pos     = data_reg.x_pos;
    assign results.y_pos     = data_reg.y_pos;
    assign results.touched   = data_reg.touched;

endmodule

`default_nettype wire

/* rtl/touch_packet_parser.sv */
// Top level: serial touchscreen packet parser.
//
//   channel   dir   payload                                   per item
//   bytes     in    rx_byte[7:0]                              one received byte
//   results   out   packet_ok, x_pos[15:0], y_pos[15:0] s,    one per carriage return
//                   touched
//
// One byte is taken every cycle while no carriage return is held up in the input
// register; digits are accumulated as each byte arrives. A carriage return is
// taken into the input register, and its result is loaded from there into the
// result register, which offers it. Reset clears the byte count and both
// valid flags. A carriage return waits in the input register while the result
// register is full and not being taken; other bytes pass on regardless.
`timescale 1ns / 1ps
`default_nettype none

module touch_packet_parser (
    input  logic       clk,
    input  logic       rst_n,
    tpp_in_if.sink     bytes,
    tpp_out_if.source  results
);
    import tpp_pkg::*;

    tpp_hold_t   hold;
    tpp_result_t result;
    logic        advance;
    logic        load;
    logic        can_load;

    tpp_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .hold    (hold)
    );

    tpp_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (hold),
        .can_load (can_load),
        .advance  (advance),
        .load     (load),
        .result   (result)
    );

    tpp_result_reg u_result_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .can_load (can_load),
        .results  (results)
    );

endmodule

`default_nettype wire

/* verif/touch_packet_parser_checker.sv */
// Checker: watches both channels of the packet parser and checks every result.
`timescale 1ns / 1ps

module touch_packet_parser_checker (
    input  logic clk,
    input  logic rst_n,
    tpp_in_if    bytes,
    tpp_out_if   results,
    output int   mismatches,
    output int   outstanding
);
    import tpp_pkg::*;

    localparam int X_SCALE = 4;
    localparam int Y_SCALE = 3;
    localparam int DECIMAL = 10;

    logic [COUNT_W-1:0] fill;
    logic [7:0]         frame_bytes [PACKET_BYTES];
    tpp_result_t        pending_results [$];
    tpp_result_t        want;

    // Value of the leading decimal digits between two buffer positions
    function automatic int field_value(input int first, input int last);
        int v;
        v = 0;
        for (int i = first; i <= last; i++)
        begin
            if (frame_bytes[i] < CH_ZERO || frame_bytes[i] > CH_NINE)
                break;
            v = v * DECIMAL + int'(frame_bytes[i] - CH_ZERO);
        end
        return v;
    endfunction

    function automatic tpp_result_t decode_frame();
        tpp_result_t r;
        int          xv;
        int          yv;
        r = '0;
        if (fill == COUNT_FULL && frame_bytes[POS_COMMA] == CH_COMMA &&
            (frame_bytes[POS_TYPE] == CH_TOUCH || frame_bytes[POS_TYPE] == CH_RELEASE))
        begin
            xv = field_value(int'(POS_X_FIRST), int'(POS_X_LAST)) * X_SCALE;
            yv = int'(Y_ORIGIN) - Y_SCALE * field_value(int'(POS_Y_FIRST), int'(POS_Y_LAST));
            r.packet_ok = 1'b1;
            r.x_pos     = POS_W'(xv);
            r.y_pos     = POS_W'(yv);
            r.touched   = frame_bytes[POS_TYPE] == CH_TOUCH;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, wanted);
        mismatches++;
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = '0;
            pending_results.delete();
        end
        else
        begin
            if (bytes.valid && bytes.ready)
            begin
                if (bytes.rx_byte == CH_CR)
                begin
                    pending_results.push_back(decode_frame());
                    fill = '0;
                end
                else if (fill < COUNT_FULL)
                begin
                    frame_bytes[fill] = bytes.rx_byte;
                    fill = fill + COUNT_W'(1);
                end
                // drop bytes beyond a full packet
            end
            if (results.valid && results.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, packet_ok", int'(results.packet_ok), 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (results.packet_ok !== want.packet_ok)
                        report_mismatch("packet_ok", int'(results.packet_ok),
                                        int'(want.packet_ok));
                    if (results.x_pos !== want.x_pos)
                        report_mismatch("x_pos", int'(results.x_pos), int'(want.x_pos));
                    if (results.y_pos !== want.y_pos)
                        report_mismatch("y_pos", int'(results.y_pos), int'(want.y_pos));
                    if (results.touched !== want.touched)
                        report_mismatch("touched", int'(results.touched), int'(want.touched));
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

/* verif/touch_packet_parser_tb.sv */
// Testbench top: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module touch_packet_parser_tb;
    import tpp_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_BYTES = 350;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    bit   quiet;
    int   sent;
    logic [7:0] frame [$];

    tpp_in_if  bytes ();
    tpp_out_if results ();

    touch_packet_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .results (results)
    );

    touch_packet_parser_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .results     (results),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] any_but_cr();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] field_byte();
        if ($urandom_range(0, 9) < 8)
            return CH_ZERO + 8'($urandom_range(0, 9));
        return any_but_cr();
    endfunction

    // Called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            bytes.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bytes.valid   <= 1'b1;
        bytes.rx_byte <= b;
        do
            @(posedge clk);
        while (!bytes.ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        send_byte(CH_CR);
    endtask

    task automatic send_text(input string s);
        frame.delete();
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i]);
        send_frame();
    endtask

    // Hold the sender until every pending result has gone out
    task automatic hold_until_drained();
        bytes.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic make_random_frame();
        int kind;
        kind = $urandom_range(0, 99);
        frame.delete();
        if (kind < 75)
        begin
            if ($urandom_range(0, 9) < 9)
                frame.push_back($urandom_range(0, 1) ? CH_TOUCH : CH_RELEASE);
            else
                frame.push_back(any_but_cr());
            repeat (4) frame.push_back(field_byte());
            frame.push_back($urandom_range(0, 9) < 9 ? CH_COMMA : any_but_cr());
            repeat (4) frame.push_back(field_byte());
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 4)) frame.push_back(any_but_cr());
        end
        else
        begin
            // noise, which may carry stray carriage returns of its own
            repeat ($urandom_range(0, 14)) frame.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left    = 0;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                results.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap() + 1;
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int frames;
        int goal;
        rst_n         = 1'b0;
        bytes.valid   = 1'b0;
        bytes.rx_byte = '0;
        quiet         = 1'b0;
        sent          = 0;
        frames        = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed packets
        send_text("");
        send_text("T1234,5678");
        send_text("R0000,0000");
        send_text("T9999,9999");
        send_text("T12ab,34cdXYZ");
        send_text("R1234,56789");
        send_text("T123,456");
        send_text("X1234,5678");
        send_text("T1234;5678");
        send_text("Ta123,b456");
        send_text("R/123,:456");
        send_text("T0/12,9:12");
        frame.delete();
        frame.push_back(8'hff);
        repeat (4) frame.push_back(8'h00);
        frame.push_back(CH_COMMA);
        repeat (4) frame.push_back(8'hff);
        send_frame();
        frame[0] = CH_RELEASE;
        send_frame();
        hold_until_drained();

        goal = sent + RANDOM_BYTES;
        while (sent < goal)
        begin
            if (frames % 8 == 0)
                quiet = $urandom_range(0, 3) == 0;
            if (frames == 20)
                hold_until_drained();
            make_random_frame();
            send_frame();
            frames++;
        end
        bytes.valid <= 1'b0;
        quiet = 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
